/* hw/rtl/chf_pkg.sv */
// ----------------------------------------------------------------------------
// chf_pkg
// Shared constants for the hysteresis flood block.
// ----------------------------------------------------------------------------
package chf_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_PIXEL   = 2'd1;
  localparam logic [1:0] KIND_REFUSED = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HIGH   = 2'd2;
  localparam logic [1:0] REG_LOW    = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

endpackage

/* hw/rtl/chf_stack.sv */
// ----------------------------------------------------------------------------
// chf_stack
// Flood stack memory with a registered read of the entry at rd_addr.
// ----------------------------------------------------------------------------
module chf_stack #(
  parameter int AW = 16,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* hw/rtl/canny_hysteresis_flood.sv */
// ----------------------------------------------------------------------------
// canny_hysteresis_flood
// Loads a frame, runs a hysteresis flood over a stack, returns pixels with their edge marks.
// ----------------------------------------------------------------------------
// Channel   Ports                                   Direction
// input     start, busy (out), in_cmd, in_magnitude  in
// result    out_valid, out_kind, out_pixel_value,
//           out_is_edge, out_last_pixel             out
// config    cfg_we, cfg_index, cfg_data             in
//
// A load or read is accepted, then holds busy; a read's result strobe is high
// in the cycle after busy, as busy falls, and a new item may be accepted then.
// The last load clears the mark memory (one entry a cycle), then scans the
// interior with S_SEED, S_SEEDC and S_DONE per pixel, and each popped pixel
// runs its nine neighbor read/modify steps through S_NRD and S_NCHK.
// Reset is synchronous; results are strobed and cannot be stalled.
module canny_hysteresis_flood #(
  parameter int MAX_WIDTH  = chf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = chf_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [15:0] in_magnitude,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [15:0] out_pixel_value,
  output logic        out_is_edge,
  output logic        out_last_pixel,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import chf_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int TW = AW + 1;
  localparam int CXW = $clog2(MAX_WIDTH);
  localparam int CYW = $clog2(MAX_HEIGHT);
  localparam int SW = CXW + CYW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_SEED  = 4'd3;
  localparam logic [3:0] S_SEEDC = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_POPW  = 4'd6;
  localparam logic [3:0] S_NRD   = 4'd7;
  localparam logic [3:0] S_NCHK  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [8:0]  fw_r, fh_r;
  logic [15:0] hi_r, lo_r;
  logic [3:0]  st_r;
  logic        reading_r;
  logic [TW-1:0] lpos_r, rpos_r;
  logic        cmd_r;
  logic [15:0] mag_r;
  logic [XW-1:0] w;
  logic [YW-1:0] h;
  logic [TW-1:0] total;
  logic [AW-1:0] ci_r;
  logic [XW-1:0] sx_r, px_r, nx_r;
  logic [YW-1:0] sy_r, py_r, ny_r;
  logic [AW-1:0] pb_r;
  logic [TW-1:0] sp_r;

  logic [15:0] mag_mem [2**AW];
  logic        mark_mem [2**AW];
  logic [AW-1:0] m_addr;
  logic        m_we, mk_we, mk_val;
  logic [15:0] m_q;
  logic        mk_q;

  logic          stk_we;
  logic [AW-1:0] stk_waddr;
  logic [SW-1:0] stk_wdata, stk_q;

  always_comb begin
    w = (fw_r < 9'd3) ? XW'(3) : (32'(fw_r) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(fw_r);
    h = (fh_r < 9'd3) ? YW'(3) : (32'(fh_r) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(fh_r);
  end

  assign total = TW'(w) * TW'(h);

  logic [TW-1:0] lclamp, rclamp;
  assign lclamp = (lpos_r < total) ? lpos_r : total - TW'(1);
  assign rclamp = (rpos_r < total) ? rpos_r : total - TW'(1);

  always_ff @(posedge clk) begin
    if (m_we) mag_mem[m_addr] <= mag_r;
    m_q <= mag_mem[m_addr];
    if (mk_we) mark_mem[m_addr] <= mk_val;
    mk_q <= mark_mem[m_addr];
  end

  chf_stack #(.AW(AW), .DW(SW)) u_stack (
    .clk(clk), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
    .rd_addr(AW'(sp_r - TW'(1))), .rd_data(stk_q)
  );

  logic        nb_ok;
  always_comb begin
    nb_ok = (nx_r >= XW'(1)) && (nx_r <= XW'(w - XW'(2))) && (ny_r >= YW'(1))
         && (ny_r <= YW'(h - YW'(2)));
  end

  logic [AW-1:0] nidx;
  assign nidx = AW'(pb_r + AW'(ny_r) * AW'(w) + AW'(nx_r));

  always_comb begin
    m_addr = '0; m_we = 1'b0; mk_we = 1'b0; mk_val = 1'b0;
    stk_we = 1'b0; stk_waddr = AW'(sp_r); stk_wdata = '0;
    case (st_r)
      S_IDLE:  m_addr = (in_cmd == CMD_LOAD) ? AW'(lclamp) : AW'(rclamp);
      S_ACC: begin
        m_addr = AW'(lclamp);
        m_we = (cmd_r == CMD_LOAD);
      end
      S_CLR: begin m_addr = ci_r; mk_we = 1'b1; end
      S_SEED:  m_addr = AW'(AW'(sy_r) * AW'(w) + AW'(sx_r));
      S_SEEDC: begin
        m_addr = AW'(AW'(sy_r) * AW'(w) + AW'(sx_r));
        if (m_q >= hi_r && !mk_q) begin
          mk_we = 1'b1; mk_val = 1'b1; stk_we = 1'b1;
          stk_wdata = {CYW'(sy_r), CXW'(sx_r)};
        end
      end
      S_NRD:   m_addr = nidx;
      S_NCHK: begin
        m_addr = nidx;
        if (nb_ok && m_q > lo_r && !mk_q) begin
          mk_we = 1'b1; mk_val = 1'b1; stk_we = 1'b1;
          stk_wdata = {CYW'(ny_r), CXW'(nx_r)};
        end
      end
      default: ;
    endcase
  end

  logic [3:0]    nk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; reading_r <= 1'b0; lpos_r <= '0; rpos_r <= '0;
      fw_r <= 9'd256; fh_r <= 9'd256; hi_r <= 16'hFFFF; lo_r <= 16'h0000;
      out_valid <= 1'b0; sp_r <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  fw_r <= cfg_data[8:0];
          REG_HEIGHT: fh_r <= cfg_data[8:0];
          REG_HIGH:   hi_r <= cfg_data;
          REG_LOW:    lo_r <= cfg_data;
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: if (start) begin
          cmd_r <= in_cmd; mag_r <= in_magnitude;
          if (in_cmd == CMD_LOAD && reading_r) begin
            reading_r <= 1'b0; lpos_r <= '0; rpos_r <= '0;
          end
          st_r <= S_ACC;
        end
        S_ACC: begin
          st_r <= S_IDLE;
          out_pixel_value <= 16'h0; out_is_edge <= 1'b0; out_last_pixel <= 1'b0;
          if (cmd_r == CMD_LOAD) begin
            if (lclamp + TW'(1) >= total) begin
              ci_r <= '0; st_r <= S_CLR;
            end else lpos_r <= lclamp + TW'(1);
          end else if (!reading_r) begin
            out_valid <= 1'b1; out_kind <= KIND_REFUSED;
          end else begin
            out_valid <= 1'b1; out_kind <= KIND_PIXEL;
            out_pixel_value <= m_q; out_is_edge <= mk_q;
            if (rclamp + TW'(1) >= total) begin
              out_last_pixel <= 1'b1; reading_r <= 1'b0;
              rpos_r <= '0; lpos_r <= '0;
            end else rpos_r <= rclamp + TW'(1);
          end
        end
        S_CLR: begin
          ci_r <= ci_r + AW'(1);
          if (TW'(ci_r) + TW'(1) >= total) begin
            sx_r <= XW'(1); sy_r <= YW'(1); sp_r <= '0; st_r <= S_SEED;
          end
        end
        S_SEED: st_r <= S_SEEDC;
        S_SEEDC: begin
          if (m_q >= hi_r && !mk_q) begin
            sp_r <= sp_r + TW'(1); st_r <= S_POP;
          end else st_r <= S_DONE;
        end
        S_POP: st_r <= S_POPW;
        S_POPW: begin
          sp_r <= sp_r - TW'(1);
          py_r <= YW'(stk_q[SW-1:CXW]); px_r <= XW'(stk_q[CXW-1:0]);
          pb_r <= '0;
          nx_r <= XW'(stk_q[CXW-1:0]) - XW'(1);
          ny_r <= YW'(stk_q[SW-1:CXW]) - YW'(1);
          nk_r <= '0;
          st_r <= S_NRD;
        end
        S_NRD: st_r <= S_NCHK;
        S_NCHK: begin
          if (nb_ok && m_q > lo_r && !mk_q) sp_r <= sp_r + TW'(1);
          if (nk_r == 4'd8) begin
            st_r <= ((nb_ok && m_q > lo_r && !mk_q) || sp_r != '0) ? S_POP : S_DONE;
          end else begin
            nk_r <= nk_r + 4'd1;
            if (nx_r == px_r + XW'(1)) begin
              nx_r <= px_r - XW'(1); ny_r <= ny_r + YW'(1);
            end else nx_r <= nx_r + XW'(1);
            st_r <= S_NRD;
          end
        end
        S_DONE: begin
          if (sx_r + XW'(2) < w) begin
            sx_r <= sx_r + XW'(1); st_r <= S_SEED;
          end else if (YW'(sy_r + YW'(2)) < h) begin
            sx_r <= XW'(1); sy_r <= sy_r + YW'(1); st_r <= S_SEED;
          end else begin
            out_valid <= 1'b1; out_kind <= KIND_DONE;
            lpos_r <= '0; rpos_r <= '0; reading_r <= 1'b1; st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (st_r != S_IDLE);

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r) != S_IDLE) else $error("result without work");
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer not taken");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DONE) |-> sp_r == '0) else $error("stack not empty");
endmodule
